// ===== rtl/pls_pkg.sv =====
// Shared types and constants for the positional list store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    // List geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 5;              // count field width
    localparam int POS_W  = 5;              // position field width
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_END = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_AT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISPLAY = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DISP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request fields
        logic exec;       // perform the latched operation
        logic disp_step;  // emit one stored value and advance
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_disp;    // latched request is a display
        logic is_valid;   // latched function code is defined
        logic empty;      // list holds no entries
        logic disp_last;  // display index sits on the final entry
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// Sequencer for the positional list store.
// Depends on pls_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_valid && i_stat.is_disp && !i_stat.empty) begin
                    n_state = S_DISP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                o_cmd.disp_step = 1'b1;
                if (i_stat.disp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pls_datapath.sv =====
// Entry store, count and result registers of the positional list store.
// Depends on pls_pkg for widths, codes and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module pls_datapath
    import pls_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire logic        [FUNC_W-1:0] i_func,
    input  wire logic        [POS_W-1:0]  i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output t_stat                         o_stat,
    output logic                          o_strobe,
    output logic signed      [DATA_W-1:0] o_value_out,
    output logic                          o_is_last,
    output logic             [CNT_W-1:0]  o_count,
    output logic             [1:0]        o_status
);

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Latched request
    logic        [FUNC_W-1:0] r_func;
    logic        [POS_W-1:0]  r_pos;
    logic        [DATA_W-1:0] r_value;

    // List state
    logic [DATA_W-1:0] r_entries [DEPTH];
    logic [DATA_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx;

    // Result registers
    logic              r_strobe;
    logic [DATA_W-1:0] r_value_out;
    logic              r_is_last;
    logic [CNT_W-1:0]  r_out_count;
    t_status           r_status;

    logic              is_insert, is_delete, do_insert, do_delete, emit_exec;
    logic [CNT_W-1:0]  ins_pos, del_pos;
    t_status           op_status;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    // Operation decode and checks
    always_comb begin
        is_insert = (r_func == FN_APPEND) || (r_func == FN_INSERT);
        is_delete = (r_func == FN_DEL_END) || (r_func == FN_DEL_AT);
        ins_pos   = (r_func == FN_APPEND) ? (r_count + CNT_ONE) : CNT_W'(r_pos);
        del_pos   = (r_func == FN_DEL_END) ? r_count : CNT_W'(r_pos);
        do_insert = 1'b0;
        do_delete = 1'b0;
        op_status = ST_OK;
        if (is_insert) begin
            priority if (ins_pos < CNT_ONE || ins_pos > r_count + CNT_ONE) begin
                op_status = ST_RANGE;
            end else if (r_count >= CNT_FULL) begin
                op_status = ST_FULL;
            end else begin
                do_insert = 1'b1;
            end
        end else if (is_delete) begin
            priority if (r_count == '0) begin
                op_status = ST_EMPTY;
            end else if (del_pos < CNT_ONE || del_pos > r_count) begin
                op_status = ST_RANGE;
            end else begin
                do_delete = 1'b1;
            end
        end else if (r_count == '0) begin
            op_status = ST_EMPTY;  // display of an empty list
        end
        emit_exec = is_insert || is_delete ||
                    ((r_func == FN_DISPLAY) && (r_count == '0));
    end

    // Shift network: each slot looks at its neighbours only
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_insert) begin
                if (CNT_W'(i) == ins_pos - CNT_ONE) begin
                    n_entries[i] = r_value;
                end else if (i > 0 && CNT_W'(i) >= ins_pos) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_delete) begin
                if (CNT_W'(i) >= del_pos - CNT_ONE) begin
                    n_entries[i] = (i < DEPTH - 1) ? r_entries[(i < DEPTH - 1) ? i + 1 : i]
                                                   : '0;
                end
            end
        end
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_ONE;
        end else if (do_delete) begin
            n_count = r_count - CNT_ONE;
        end
    end

    // List state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_count   <= n_count;
            r_entries <= n_entries;
        end
    end

    // Display index
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.disp_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.exec && emit_exec) || i_cmd.disp_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_value_out <= '0;
            r_is_last   <= 1'b1;
            r_out_count <= n_count;
            r_status    <= op_status;
        end else if (i_cmd.disp_step) begin
            r_value_out <= r_entries[r_idx];
            r_is_last   <= o_stat.disp_last;
            r_out_count <= r_count;
            r_status    <= ST_OK;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.is_disp   = (r_func == FN_DISPLAY);
        o_stat.is_valid  = (r_func <= FN_DISPLAY);
        o_stat.empty     = (r_count == '0);
        o_stat.disp_last = ({1'b0, r_idx} + CNT_ONE) == r_count;
    end

    assign o_strobe    = r_strobe;
    assign o_value_out = r_value_out;
    assign o_is_last   = r_is_last;
    assign o_count     = r_out_count;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// Positional list store: bounded ordered list with append, insert, delete and display.
// Non-display request: busy in the controller EXEC step after acceptance; the result strobe is
// registered from EXEC (none for an undefined code); a new request is taken back in IDLE.
// Display of n entries: EXEC, then n results on consecutive cycles in DISP, busy until back in IDLE.
// Synchronous active-low reset clears every entry, the count and the strobe at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store
    import pls_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [FUNC_W-1:0] i_func,
    input  wire logic        [POS_W-1:0]  i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_strobe,
    output logic signed      [DATA_W-1:0] o_value_out,
    output logic                          o_is_last,
    output logic             [CNT_W-1:0]  o_count,
    output logic             [1:0]        o_status
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    pls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Store and result path
    pls_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_value_out (o_value_out),
        .o_is_last   (o_is_last),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_last) |=> !o_strobe)
        else $error("result strobe directly after a final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_count <= CNT_W'(DEPTH)))
        else $error("count beyond list depth");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_is_last && o_value_out == '0))
        else $error("failed request gave a non-final or non-zero result");

endmodule

`default_nettype wire
